// ===== src/wasm_pkg.sv =====
// shared types, constants and helpers for the weekly alarm slot matcher
`default_nettype none

package wasm_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SET_EN = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned MaskW    = 7;
  localparam int unsigned ProgW    = 8;
  localparam int unsigned YearW    = 9;
  localparam int unsigned DayW     = 9;
  localparam int unsigned KeyW     = YearW + DayW;
  localparam int unsigned EntryW   = HourW + MinuteW + MaskW + ProgW;
  localparam int unsigned MemW     = KeyW + EntryW;
  localparam int unsigned CountW   = 4;
  localparam int unsigned FireCntW = 4;

  localparam logic [HourW-1:0]    HourMax   = 5'd23;
  localparam logic [MinuteW-1:0]  MinuteMax = 6'd59;
  localparam logic [MaskW-1:0]    AllDays   = 7'h7F;
  localparam logic [FireCntW-1:0] MaxFires  = 4'd8;

  typedef struct packed {
    logic latch;       // capture the transaction fields
    logic scan_init;   // clear scan pointers before a tick
    logic load;        // write a slot from the input ports
    logic set_en;      // write a slot enable bit from the input ports
    logic scan_step;   // advance the slot scan
    logic push_query;  // place the query answer in the output register
    logic push_final;  // place the held firing, marked last
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic pend_vld;
  } dp_sts_t;

  // mask bit for a weekday, bit0 monday to bit6 sunday; invalid day matches nothing
  function automatic logic [MaskW-1:0] dow_bit(input logic [2:0] wd);
    logic [MaskW-1:0] b;
    b = '0;
    case (wd)
      3'd0:    b = 7'b100_0000;
      3'd1:    b = 7'b000_0001;
      3'd2:    b = 7'b000_0010;
      3'd3:    b = 7'b000_0100;
      3'd4:    b = 7'b000_1000;
      3'd5:    b = 7'b001_0000;
      3'd6:    b = 7'b010_0000;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/wasm_ctrl.sv =====
// controller state machine of the weekly alarm slot matcher
`default_nettype none

module wasm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           operation_i,
  output logic                      in_ready_o,
  input  wire wasm_pkg::dp_sts_t    sts_i,
  output wasm_pkg::ctrl_cmd_t       cmd_o
);
  import wasm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_TICK:  state_d = ST_SCAN;
            OP_QUERY: state_d = ST_QUERY;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_QUERY: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!sts_i.pend_vld || sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (op_e'(operation_i))
            OP_TICK:   cmd_o.scan_init = 1'b1;
            OP_LOAD:   cmd_o.load      = 1'b1;
            OP_SET_EN: cmd_o.set_en    = 1'b1;
            default:   cmd_o.latch     = 1'b1;
          endcase
        end
      end
      ST_QUERY: begin
        cmd_o.push_query = sts_i.out_free;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_FLUSH: begin
        cmd_o.push_final = sts_i.pend_vld && sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/wasm_dp.sv =====
// datapath of the weekly alarm slot matcher: slot memory, scan pipeline, output register
`default_nettype none

module wasm_dp #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire wasm_pkg::ctrl_cmd_t           cmd_i,
  output wasm_pkg::dp_sts_t                  sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wasm_pkg::CountW-1:0]   cfg_wdata_i,
  input  wire logic [wasm_pkg::YearW-1:0]    year_since_1900_i,
  input  wire logic [wasm_pkg::DayW-1:0]     day_of_year_i,
  input  wire logic [2:0]                    weekday_i,
  input  wire logic [wasm_pkg::HourW-1:0]    now_hour_i,
  input  wire logic [wasm_pkg::MinuteW-1:0]  now_minute_i,
  input  wire logic [2:0]                    slot_index_i,
  input  wire logic [wasm_pkg::HourW-1:0]    alarm_hour_i,
  input  wire logic [wasm_pkg::MinuteW-1:0]  alarm_minute_i,
  input  wire logic [wasm_pkg::MaskW-1:0]    days_mask_i,
  input  wire logic [wasm_pkg::ProgW-1:0]    program_number_i,
  input  wire logic                          enable_flag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         fired_slot_o,
  output logic [wasm_pkg::ProgW-1:0]         fired_program_o,
  output logic                               enabled_state_o,
  output logic                               last_result_o
);
  import wasm_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // configuration
  logic [CountW-1:0] slot_count_q;
  logic [CountW-1:0] lim;

  // captured transaction
  logic [KeyW-1:0]    key_q;
  logic [MaskW-1:0]   dow_q;
  logic [HourW-1:0]   hour_q;
  logic [MinuteW-1:0] minute_q;
  logic [2:0]         qidx_q;

  // slot memory: last fire day, program, mask, minute, hour
  logic [MemW-1:0] mem [SLOTS];
  logic [MemW-1:0] rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [MemW-1:0] mem_wdata;
  logic            rd_en;

  logic [SLOTS-1:0] en_q;

  // scan pipeline
  logic [CountW-1:0]   rd_idx_q, chk_idx_q;
  logic                chk_vld_q;
  logic [FireCntW-1:0] cnt_q, cnt_after;
  logic                pend_vld_q;
  logic [2:0]          pend_slot_q;
  logic [ProgW-1:0]    pend_prog_q;

  // output register
  logic             out_vld_q;
  logic [2:0]       out_slot_q;
  logic [ProgW-1:0] out_prog_q;
  logic             out_en_q;
  logic             out_last_q;
  logic             out_free;

  logic             in_range_i, in_range_q;
  logic [AW-1:0]    in_addr;
  logic [HourW-1:0]   e_hour;
  logic [MinuteW-1:0] e_min;
  logic [MaskW-1:0]   e_mask, e_mask_eff;
  logic [ProgW-1:0]   e_prog;
  logic [KeyW-1:0]    e_day;
  logic               hit_raw, stall, fire, can_issue, step_ok;

  assign in_range_i = 32'(slot_index_i) < SLOTS;
  assign in_range_q = 32'(qidx_q) < SLOTS;
  assign in_addr    = AW'(slot_index_i);
  assign lim        = (32'(slot_count_q) < SLOTS) ? slot_count_q : CountW'(SLOTS);
  assign out_free   = !out_vld_q || out_ready_i;

  assign e_hour     = rdata_q[HourW-1:0];
  assign e_min      = rdata_q[HourW +: MinuteW];
  assign e_mask     = rdata_q[HourW+MinuteW +: MaskW];
  assign e_prog     = rdata_q[HourW+MinuteW+MaskW +: ProgW];
  assign e_day      = rdata_q[EntryW +: KeyW];
  assign e_mask_eff = (e_mask == '0) ? AllDays : e_mask;

  assign hit_raw = chk_vld_q && en_q[AW'(chk_idx_q)] && (e_prog != '0)
                && (e_hour <= HourMax) && (e_min <= MinuteMax)
                && ((e_mask_eff & dow_q) != '0)
                && (e_hour == hour_q) && (e_min == minute_q)
                && (e_day != key_q) && (cnt_q < MaxFires);
  assign stall     = hit_raw && pend_vld_q && !out_free;
  assign step_ok   = cmd_i.scan_step && !stall;
  assign fire      = step_ok && hit_raw;
  assign cnt_after = cnt_q + FireCntW'(fire);
  assign can_issue = (rd_idx_q < lim) && (cnt_after < MaxFires);
  assign rd_en     = step_ok && can_issue;

  assign sts_o.out_free  = out_free;
  assign sts_o.scan_done = !chk_vld_q && !((rd_idx_q < lim) && (cnt_q < MaxFires));
  assign sts_o.pend_vld  = pend_vld_q;

  // memory write port: load from the ports, or stamp the day key on a firing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata = {{KeyW{1'b0}}, program_number_i, days_mask_i, alarm_minute_i, alarm_hour_i};
    if (cmd_i.load && in_range_i) begin
      mem_we = 1'b1;
    end else if (fire) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(chk_idx_q);
      mem_wdata = {key_q, rdata_q[EntryW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[AW'(rd_idx_q)];
    end
  end

  // captured fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      key_q    <= {year_since_1900_i, day_of_year_i};
      dow_q    <= dow_bit(weekday_i);
      hour_q   <= now_hour_i;
      minute_q <= now_minute_i;
      qidx_q   <= slot_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= '0;
      en_q         <= '0;
    end else begin
      if (cfg_we_i) slot_count_q <= cfg_wdata_i;
      if ((cmd_i.load || cmd_i.set_en) && in_range_i) en_q[in_addr] <= enable_flag_i;
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      chk_idx_q  <= '0;
      chk_vld_q  <= 1'b0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      rd_idx_q   <= '0;
      chk_vld_q  <= 1'b0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (step_ok) begin
        chk_vld_q <= can_issue;
        cnt_q     <= cnt_after;
        if (can_issue) begin
          chk_idx_q <= rd_idx_q;
          rd_idx_q  <= rd_idx_q + 1'b1;
        end
      end
      if (fire) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.push_final) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_slot_q <= 3'(chk_idx_q);
      pend_prog_q <= e_prog;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.push_query || cmd_i.push_final || (fire && pend_vld_q)) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_query) begin
      out_slot_q <= qidx_q;
      out_prog_q <= '0;
      out_en_q   <= in_range_q && en_q[AW'(qidx_q)];
      out_last_q <= 1'b1;
    end else if (cmd_i.push_final || (fire && pend_vld_q)) begin
      out_slot_q <= pend_slot_q;
      out_prog_q <= pend_prog_q;
      out_en_q   <= 1'b1;
      out_last_q <= cmd_i.push_final;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign fired_slot_o    = out_slot_q;
  assign fired_program_o = out_prog_q;
  assign enabled_state_o = out_en_q;
  assign last_result_o   = out_last_q;

endmodule

`default_nettype wire

// ===== src/weekly_alarm_slot_matcher.sv =====
// top level of the weekly alarm slot matcher
`default_nettype none

// Weekly alarm slot matcher: a bank of SLOTS alarm slots (hour, minute,
// weekday mask, program, enable bit, day of last firing). A tick transaction
// scans slots 0 .. min(slot_count, SLOTS)-1 in ascending order, one slot per
// cycle unless stalled, through the single read port of the slot memory,
// and sends one result per firing (at most 8 per tick), the last one flagged by
// last_result_o. A tick keeps in_ready_o low until its scan has ended, early once
// the eighth firing ends it, and the held firing, if any, has been placed in
// the output register; each further firing stalls the scan while the output
// register is still full. Load and set enable complete in the accept cycle; a
// query waits in the query state while the output register is full and yields
// one result. Inputs are accepted whenever the controller is idle, even while
// a result still waits in the output register. slot_count is written through
// cfg_we_i / cfg_wdata_i while the block is idle; slots never loaded must not
// be scanned or queried for program data.
module weekly_alarm_slot_matcher #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [wasm_pkg::CountW-1:0]   cfg_wdata_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [wasm_pkg::YearW-1:0]    year_since_1900_i,
  input  wire logic [wasm_pkg::DayW-1:0]     day_of_year_i,
  input  wire logic [2:0]                    weekday_i,
  input  wire logic [wasm_pkg::HourW-1:0]    now_hour_i,
  input  wire logic [wasm_pkg::MinuteW-1:0]  now_minute_i,
  input  wire logic [2:0]                    slot_index_i,
  input  wire logic [wasm_pkg::HourW-1:0]    alarm_hour_i,
  input  wire logic [wasm_pkg::MinuteW-1:0]  alarm_minute_i,
  input  wire logic [wasm_pkg::MaskW-1:0]    days_mask_i,
  input  wire logic [wasm_pkg::ProgW-1:0]    program_number_i,
  input  wire logic                          enable_flag_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         fired_slot_o,
  output logic [wasm_pkg::ProgW-1:0]         fired_program_o,
  output logic                               enabled_state_o,
  output logic                               last_result_o
);
  import wasm_pkg::*;

  // command and status between controller and datapath
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // controller: idle / query / scan / flush sequencing
  wasm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: slot memory, enable bits, scan pipeline, held firing, output register
  wasm_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .year_since_1900_i (year_since_1900_i),
    .day_of_year_i     (day_of_year_i),
    .weekday_i         (weekday_i),
    .now_hour_i        (now_hour_i),
    .now_minute_i      (now_minute_i),
    .slot_index_i      (slot_index_i),
    .alarm_hour_i      (alarm_hour_i),
    .alarm_minute_i    (alarm_minute_i),
    .days_mask_i       (days_mask_i),
    .program_number_i  (program_number_i),
    .enable_flag_i     (enable_flag_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fired_slot_o      (fired_slot_o),
    .fired_program_o   (fired_program_o),
    .enabled_state_o   (enabled_state_o),
    .last_result_o     (last_result_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb_weekly_alarm_slot_matcher.sv =====
// self-checking testbench for the weekly alarm slot matcher with an inline slot predictor
module tb_weekly_alarm_slot_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import wasm_pkg::*;

  localparam int unsigned NUM_SLOTS      = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles with no transaction on either side
  localparam int unsigned SETTLE_CYCLES  = 20;    // a tick with no firing can still be scanning
  localparam int unsigned PHASE_ITEMS    = 45;

  // one stored alarm, as the predictor keeps it
  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [MaskW-1:0]   mask;
    logic [ProgW-1:0]   prog;
  } alarm_slot_t;

  // one input transaction, every field at its port width
  typedef struct packed {
    op_e                op;
    logic [YearW-1:0]   year;
    logic [DayW-1:0]    day;
    logic [2:0]         wd;
    logic [HourW-1:0]   now_h;
    logic [MinuteW-1:0] now_m;
    logic [2:0]         idx;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [MaskW-1:0]   mask;
    logic [ProgW-1:0]   prog;
    logic               en;
  } alarm_req_t;

  // one output transaction: a firing or a query answer
  typedef struct packed {
    logic [2:0]       slot;
    logic [ProgW-1:0] prog;
    logic             enabled;
    logic             last;
  } alarm_fire_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CountW-1:0]  cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         operation_i;
  logic [YearW-1:0]   year_since_1900_i;
  logic [DayW-1:0]    day_of_year_i;
  logic [2:0]         weekday_i;
  logic [HourW-1:0]   now_hour_i;
  logic [MinuteW-1:0] now_minute_i;
  logic [2:0]         slot_index_i;
  logic [HourW-1:0]   alarm_hour_i;
  logic [MinuteW-1:0] alarm_minute_i;
  logic [MaskW-1:0]   days_mask_i;
  logic [ProgW-1:0]   program_number_i;
  logic               enable_flag_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         fired_slot_o;
  logic [ProgW-1:0]   fired_program_o;
  logic               enabled_state_o;
  logic               last_result_o;

  // predictor state, mirrors the block after reset
  alarm_slot_t       alarm_tbl [NUM_SLOTS];
  logic              alarm_en  [NUM_SLOTS];
  logic [KeyW-1:0]   fired_key [NUM_SLOTS];
  logic [CountW-1:0] slot_count_q;

  alarm_fire_t       pending_fires [$];  // firings and answers still owed by the block
  alarm_fire_t       head_fire;
  int                fail_count   = 0;
  int                stall_cycles = 0;
  bit                steady       = 1'b0;  // both sides run without idling

  // calendar the random ticks walk along
  logic [YearW-1:0]  cur_year = 9'd126;
  logic [DayW-1:0]   cur_day  = 9'd0;

  weekly_alarm_slot_matcher #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .year_since_1900_i (year_since_1900_i),
    .day_of_year_i     (day_of_year_i),
    .weekday_i         (weekday_i),
    .now_hour_i        (now_hour_i),
    .now_minute_i      (now_minute_i),
    .slot_index_i      (slot_index_i),
    .alarm_hour_i      (alarm_hour_i),
    .alarm_minute_i    (alarm_minute_i),
    .days_mask_i       (days_mask_i),
    .program_number_i  (program_number_i),
    .enable_flag_i     (enable_flag_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fired_slot_o      (fired_slot_o),
    .fired_program_o   (fired_program_o),
    .enabled_state_o   (enabled_state_o),
    .last_result_o     (last_result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one accepted transaction and queues what it must produce
  // ---------------------------------------------------------------------------
  task automatic match_alarms(input alarm_req_t req);
    alarm_fire_t      fires [$];
    alarm_fire_t      f;
    logic [MaskW-1:0] today;
    logic [MaskW-1:0] mask;
    logic [KeyW-1:0]  key;
    int unsigned      scan_end;
    int unsigned      i;
    case (req.op)
      OP_TICK: begin
        key = {req.year, req.day};
        // mask bit of today: bit0 monday .. bit6 sunday, weekday 7 matches nothing
        if (req.wd > 3'd6) today = '0;
        else if (req.wd == 3'd0) today = 7'b100_0000;
        else today = MaskW'(1) << (req.wd - 3'd1);
        // a count beyond the bank acts as the whole bank
        scan_end = (slot_count_q > NUM_SLOTS) ? NUM_SLOTS : int'(slot_count_q);
        for (i = 0; i < scan_end && fires.size() < int'(MaxFires); i++) begin
          mask = (alarm_tbl[i].mask == '0) ? AllDays : alarm_tbl[i].mask;
          if (alarm_en[i] && alarm_tbl[i].prog != '0 &&
              alarm_tbl[i].hour <= HourMax && alarm_tbl[i].minute <= MinuteMax &&
              (mask & today) != '0 &&
              alarm_tbl[i].hour == req.now_h && alarm_tbl[i].minute == req.now_m &&
              fired_key[i] != key) begin
            f.slot    = 3'(i);
            f.prog    = alarm_tbl[i].prog;
            f.enabled = 1'b1;
            f.last    = 1'b0;
            fires.push_back(f);
            fired_key[i] = key;  // at most once per day key
          end
        end
        if (fires.size() != 0) fires[fires.size() - 1].last = 1'b1;
        foreach (fires[k]) pending_fires.push_back(fires[k]);
      end
      OP_LOAD: begin
        if (req.idx < NUM_SLOTS) begin
          alarm_tbl[req.idx] = '{hour: req.hour, minute: req.minute, mask: req.mask,
                                 prog: req.prog};
          alarm_en[req.idx]  = req.en;
          fired_key[req.idx] = '0;  // a reload forgets the last firing
        end
      end
      OP_SET_EN: begin
        if (req.idx < NUM_SLOTS) alarm_en[req.idx] = req.en;
      end
      default: begin  // OP_QUERY
        f.slot    = req.idx;
        f.prog    = '0;
        f.enabled = (req.idx < NUM_SLOTS) ? alarm_en[req.idx] : 1'b0;
        f.last    = 1'b1;
        pending_fires.push_back(f);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // idle lengths: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------
  // unused fields carry random noise
  function automatic alarm_req_t tick_req(input logic [YearW-1:0] year,
                                          input logic [DayW-1:0] day, input logic [2:0] wd,
                                          input logic [HourW-1:0] h, input logic [MinuteW-1:0] m);
    alarm_req_t req;
    req       = {$urandom, $urandom};
    req.op    = OP_TICK;
    req.year  = year;
    req.day   = day;
    req.wd    = wd;
    req.now_h = h;
    req.now_m = m;
    return req;
  endfunction

  function automatic alarm_req_t slot_req(input op_e op, input logic [2:0] idx,
                                          input logic [HourW-1:0] hour,
                                          input logic [MinuteW-1:0] minute,
                                          input logic [MaskW-1:0] mask,
                                          input logic [ProgW-1:0] prog, input logic en);
    alarm_req_t req;
    req        = {$urandom, $urandom};
    req.op     = op;
    req.idx    = idx;
    req.hour   = hour;
    req.minute = minute;
    req.mask   = mask;
    req.prog   = prog;
    req.en     = en;
    return req;
  endfunction

  // random traffic: ticks mostly aim at a stored alarm time so firings are common,
  // loads reuse a few shared times so one tick fires several slots
  function automatic alarm_req_t random_request();
    alarm_req_t  req;
    int unsigned pick;
    int unsigned src;
    req  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      req.op = OP_TICK;
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          cur_year = 9'($urandom_range(0, 511));
          cur_day  = 9'($urandom_range(0, 365));
        end else if (cur_day >= 9'd365) begin
          cur_day  = '0;
          cur_year = cur_year + 1'b1;
        end else begin
          cur_day = cur_day + 1'b1;
        end
      end
      req.year = cur_year;
      req.day  = cur_day;
      req.wd   = ($urandom_range(0, 29) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      src      = $urandom_range(0, NUM_SLOTS - 1);
      if ($urandom_range(0, 4) != 0 && alarm_tbl[src].hour <= HourMax &&
          alarm_tbl[src].minute <= MinuteMax) begin
        req.now_h = alarm_tbl[src].hour;
        req.now_m = alarm_tbl[src].minute;
      end else begin
        req.now_h = 5'($urandom_range(0, 23));
        req.now_m = 6'($urandom_range(0, 59));
      end
    end else if (pick < 72) begin
      req.op = OP_LOAD;
      case ($urandom_range(0, 5))
        0, 1: {req.hour, req.minute} = {5'd7, 6'd30};
        2:    {req.hour, req.minute} = {5'd12, 6'd0};
        3:    {req.hour, req.minute} = {5'd23, 6'd59};
        4:    {req.hour, req.minute} = {5'd0, 6'd0};
        default: ;  // keep the full-range random time, invalid ones included
      endcase
      if ($urandom_range(0, 4) == 0) req.mask = '0;
      if ($urandom_range(0, 9) == 0) req.prog = '0;
      req.en = ($urandom_range(0, 4) != 0);
    end else if (pick < 86) begin
      req.op = OP_SET_EN;
    end else begin
      req.op = OP_QUERY;
    end
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic present(input alarm_req_t req);
    operation_i       <= req.op;
    year_since_1900_i <= req.year;
    day_of_year_i     <= req.day;
    weekday_i         <= req.wd;
    now_hour_i        <= req.now_h;
    now_minute_i      <= req.now_m;
    slot_index_i      <= req.idx;
    alarm_hour_i      <= req.hour;
    alarm_minute_i    <= req.minute;
    days_mask_i       <= req.mask;
    program_number_i  <= req.prog;
    enable_flag_i     <= req.en;
  endtask

  // valid stays high after acceptance unless a gap follows, so back-to-back
  // transactions never lower and raise valid in the same step
  task automatic send_request(input alarm_req_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    present(req);
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    match_alarms(req);
  endtask

  // stop sending, wait for every owed result, then let a silent tick finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_fires.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_slot_count(input logic [CountW-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    slot_count_q = count;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random backpressure
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // every result is compared with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_fires.size() == 0) begin
        $error("result with no transaction pending: fired_slot %0d", fired_slot_o);
        fail_count++;
      end else begin
        head_fire = pending_fires.pop_front();
        if (fired_slot_o !== head_fire.slot) begin
          $error("fired_slot: expected %0d, got %0d", head_fire.slot, fired_slot_o);
          fail_count++;
        end
        if (fired_program_o !== head_fire.prog) begin
          $error("fired_program: expected %0d, got %0d", head_fire.prog, fired_program_o);
          fail_count++;
        end
        if (enabled_state_o !== head_fire.enabled) begin
          $error("enabled_state: expected %0d, got %0d", head_fire.enabled, enabled_state_o);
          fail_count++;
        end
        if (last_result_o !== head_fire.last) begin
          $error("last_result: expected %0d, got %0d", head_fire.last, last_result_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: count cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // every slot is loaded before any tick can scan it; field extremes on the way
  task automatic test_slot_load_query();
    set_slot_count(4'd0);
    send_request(slot_req(OP_LOAD, 3'd0, 5'd7, 6'd30, 7'h00, 8'd1, 1'b1));    // empty mask
    send_request(slot_req(OP_LOAD, 3'd1, 5'd7, 6'd30, 7'h7F, 8'd255, 1'b1));  // full mask
    send_request(slot_req(OP_LOAD, 3'd2, 5'd7, 6'd30, 7'h40, 8'h5A, 1'b1));   // sunday only
    send_request(slot_req(OP_LOAD, 3'd3, 5'd7, 6'd30, 7'h01, 8'hA5, 1'b0));   // monday, off
    send_request(slot_req(OP_LOAD, 3'd4, 5'd7, 6'd30, 7'h00, 8'd0, 1'b1));    // program zero
    send_request(slot_req(OP_LOAD, 3'd5, 5'd31, 6'd30, 7'h00, 8'd3, 1'b1));   // bad hour
    send_request(slot_req(OP_LOAD, 3'd6, 5'd7, 6'd63, 7'h00, 8'd4, 1'b1));    // bad minute
    send_request(slot_req(OP_LOAD, 3'd7, 5'd23, 6'd59, 7'h00, 8'd7, 1'b1));
    send_request(slot_req(OP_QUERY, 3'd3, 5'd0, 6'd0, 7'h00, 8'd0, 1'b0));
    send_request(slot_req(OP_QUERY, 3'd0, 5'd0, 6'd0, 7'h00, 8'd0, 1'b0));
    send_request(slot_req(OP_QUERY, 3'd7, 5'd0, 6'd0, 7'h00, 8'd0, 1'b0));
  endtask

  task automatic test_tick_special_cases();
    settle_block();
    set_slot_count(4'd8);
    // day key equal to the cleared one after a load: nothing fires
    send_request(tick_req(9'd0, 9'd0, 3'd1, 5'd7, 6'd30));
    // sunday: empty, full and sunday masks fire
    send_request(tick_req(9'd126, 9'd10, 3'd0, 5'd7, 6'd30));
    // same day again: already fired
    send_request(tick_req(9'd126, 9'd10, 3'd0, 5'd7, 6'd30));
    // weekday 7 matches no mask, not even an empty one
    send_request(tick_req(9'd126, 9'd11, 3'd7, 5'd7, 6'd30));
    send_request(slot_req(OP_SET_EN, 3'd3, 5'd0, 6'd0, 7'h00, 8'd0, 1'b1));
    // monday: the monday slot now joins in
    send_request(tick_req(9'd126, 9'd12, 3'd1, 5'd7, 6'd30));
    send_request(tick_req(9'd511, 9'd365, 3'd6, 5'd23, 6'd59));
    send_request(tick_req(9'd511, 9'd146, 3'd6, 5'd23, 6'd59));
    send_request(slot_req(OP_SET_EN, 3'd7, 5'd0, 6'd0, 7'h00, 8'd0, 1'b0));
    // disabled slot stays quiet on a new day
    send_request(tick_req(9'd200, 9'd5, 3'd3, 5'd23, 6'd59));
    send_request(slot_req(OP_QUERY, 3'd7, 5'd0, 6'd0, 7'h00, 8'd0, 1'b0));
  endtask

  // random traffic under several slot counts, counts above the bank included
  task automatic test_slot_count_sweep();
    logic [CountW-1:0] counts [9] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd9, 4'd3, 4'd12, 4'd8};
    foreach (counts[k]) begin
      settle_block();
      set_slot_count(counts[k]);
      repeat (PHASE_ITEMS) send_request(random_request());
    end
  endtask

  // back-to-back transactions with the output always ready
  task automatic test_steady_stream();
    settle_block();
    set_slot_count(4'd8);
    steady = 1'b1;
    repeat (PHASE_ITEMS) send_request(random_request());
    settle_block();
    steady = 1'b0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    present('0);
    foreach (alarm_tbl[i]) begin
      alarm_tbl[i] = '0;
      alarm_en[i]  = 1'b0;
      fired_key[i] = '0;
    end
    slot_count_q = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_slot_load_query();
    test_tick_special_cases();
    test_slot_count_sweep();
    test_steady_stream();
    settle_block();

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== weekly_alarm_slot_matcher.f =====
src/wasm_pkg.sv
src/wasm_ctrl.sv
src/wasm_dp.sv
src/weekly_alarm_slot_matcher.sv
sim/tb_weekly_alarm_slot_matcher.sv
